### hw/rtl/rart_pkg.sv
// ----------------------------------------------------------------------------
// rart_pkg: shared types and constants for the range address remap table
// Entry count, operation and status codes, scan record passed between cells.
// ----------------------------------------------------------------------------
package rart_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 32;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_REMAP  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ALREADY    = 3'd1,
        ST_NOT_MAPPED = 3'd2,
        ST_OFFSET     = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // running search record handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] dbase;
        logic [IDX_W-1:0]  idx;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } t_scan;

    // write command broadcast to all cells
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] dbase;
    } t_wcmd;

endpackage

### hw/rtl/range_address_remap_table_top.sv
// ----------------------------------------------------------------------------
// range_address_remap_table_top: range based address translation table
// Add, remove and translate ranges through a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one command word: func, source
//   address, range length and destination base. Output channel
//   o_valid/i_ready returns one word per command: status and dest address.
//   Each command runs as follows with a ready receiver: the accept cycle
//   and the scan cycles after it step the search record through the
//   cells, the last scan cycle decides and writes back, and the done
//   state presents the result word. Table write-back happens on the
//   decide cycle. One command is in flight at a time; the next is taken
//   once the result word has been accepted. If the receiver stalls, the
//   result holds and input stays blocked. Reset clears all entry valid
//   bits.
// ----------------------------------------------------------------------------
module range_address_remap_table_top import rart_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic [ADDR_W-1:0]   i_source_addr,
    input  logic [LEN_W-1:0]    i_range_length,
    input  logic [ADDR_W-1:0]   i_dest_base,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [ADDR_W-1:0]   o_dest_addr
);
    t_scan             chain [ENTRIES+1];
    t_wcmd             wcmd;
    logic              step;
    logic [ADDR_W-1:0] addr;

    // the record enters the chain fresh; each cell registers it
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            rart_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_my_idx(IDX_W'(g)),
                .i_step  (step),
                .i_addr  (addr),
                .i_scan  (chain[g]),
                .i_wcmd  (wcmd),
                .o_scan  (chain[g+1])
            );
        end
    endgenerate

    // cells all fire every step; after ENTRIES steps the tail has folded
    // every cell in order, cell k having seen the record on step k+1

    rart_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_source_addr (i_source_addr),
        .i_range_length(i_range_length),
        .i_dest_base   (i_dest_base),
        .i_scan_end    (chain[ENTRIES]),
        .o_step        (step),
        .o_addr        (addr),
        .o_wcmd        (wcmd),
        .o_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .o_status      (o_status),
        .o_dest_addr   (o_dest_addr)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result word dropped");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_FULL) else $error("status code out of range");
`endif
endmodule

### hw/rtl/rart_cell.sv
// ----------------------------------------------------------------------------
// rart_cell: one table entry
// Holds one translation; the scan record passes through it one step a cycle while i_step is high.
// ----------------------------------------------------------------------------
module rart_cell import rart_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_my_idx,
    input  logic              i_step,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_scan             i_scan,
    input  t_wcmd             i_wcmd,
    output t_scan             o_scan
);
    logic              r_valid;
    logic [ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_dbase;
    t_scan             r_out;
    t_scan             n_out;
    logic              sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wcmd.wr && i_wcmd.idx == i_my_idx) begin
            r_valid <= 1'b1;
        end else if (i_wcmd.clr && i_wcmd.idx == i_my_idx) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wcmd.wr && i_wcmd.idx == i_my_idx) begin
            r_base  <= i_wcmd.base;
            r_len   <= i_wcmd.len;
            r_dbase <= i_wcmd.dbase;
        end
    end

    always_comb begin
        n_out = i_scan;
        sel = r_valid && r_base <= i_addr && (!i_scan.found || r_base > i_scan.base);
        if (sel) begin
            n_out.found = 1'b1;
            n_out.base  = r_base;
            n_out.len   = r_len;
            n_out.dbase = r_dbase;
            n_out.idx   = i_my_idx;
        end
        if (!r_valid && !i_scan.free_found) begin
            n_out.free_found = 1'b1;
            n_out.free_idx   = i_my_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_out <= n_out;
        end
    end

    assign o_scan = r_out;
endmodule

### hw/rtl/rart_ctrl.sv
// ----------------------------------------------------------------------------
// rart_ctrl: sequencer and result stage
// Starts the scan, counts steps, decides the operation and writes back.
// ----------------------------------------------------------------------------
module rart_ctrl import rart_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_func,
    input  logic [ADDR_W-1:0] i_source_addr,
    input  logic [LEN_W-1:0]  i_range_length,
    input  logic [ADDR_W-1:0] i_dest_base,
    input  t_scan             i_scan_end,
    output logic              o_step,
    output logic [ADDR_W-1:0] o_addr,
    output t_wcmd             o_wcmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [ADDR_W-1:0] o_dest_addr
);
    localparam logic [IDX_W:0] LAST = (IDX_W+1)'(ENTRIES - 1);

    t_state            r_state, n_state;
    logic [IDX_W:0]    r_cnt, n_cnt;
    logic [1:0]        r_func;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_dbase;
    logic [2:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_res, n_res;
    t_wcmd             n_wcmd;
    logic [ADDR_W-1:0] offset;
    logic              in_range;
    logic              accept;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    // the accept cycle is the first step: cell 0 folds with the incoming address
    assign o_step  = (r_state == S_SCAN) || accept;
    assign o_addr  = accept ? i_source_addr : r_addr;

    assign offset = r_addr - i_scan_end.base;
    assign in_range = i_scan_end.found && offset < {{(ADDR_W-LEN_W){1'b0}}, i_scan_end.len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_addr  <= i_source_addr;
            r_len   <= i_range_length;
            r_dbase <= i_dest_base;
        end
        if (r_state == S_SCAN && r_cnt == LAST) begin
            r_status <= n_status;
            r_res    <= n_res;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_status = ST_OK;
        n_res    = '0;
        n_wcmd   = '0;
        n_wcmd.base  = r_addr;
        n_wcmd.len   = r_len;
        n_wcmd.dbase = r_dbase;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = S_DONE;
                    unique case (t_func'(r_func))
                        FUNC_ADD: begin
                            if (in_range) begin
                                n_status = ST_ALREADY;
                            end else if (i_scan_end.found && offset == '0) begin
                                n_wcmd.wr  = 1'b1;
                                n_wcmd.idx = i_scan_end.idx;
                                n_res      = r_dbase;
                            end else if (i_scan_end.free_found) begin
                                n_wcmd.wr  = 1'b1;
                                n_wcmd.idx = i_scan_end.free_idx;
                                n_res      = r_dbase;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (!in_range) begin
                                n_status = ST_NOT_MAPPED;
                            end else if (offset != '0) begin
                                n_status = ST_OFFSET;
                            end else begin
                                n_wcmd.clr = 1'b1;
                                n_wcmd.idx = i_scan_end.idx;
                            end
                        end
                        FUNC_REMAP: begin
                            if (!in_range) begin
                                n_status = ST_NOT_MAPPED;
                            end else begin
                                n_res = i_scan_end.dbase + offset;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_wcmd      = n_wcmd;
    assign o_out_valid = (r_state == S_DONE);
    assign o_status    = r_status;
    assign o_dest_addr = r_res;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cnt <= LAST) else $error("scan count overrun");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wcmd.wr && o_wcmd.clr)) else $error("write and clear together");
    a_write_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wcmd.wr || o_wcmd.clr) |=> r_state == S_DONE)
        else $error("write outside scan end");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_dest_addr) && $stable(o_status))
        else $error("result changed while stalled");
`endif
endmodule

### tb/tb_range_address_remap_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_address_remap_table_top: testbench for the range remap table
// Drives add/remove/remap/nop words, predicts status and address with a
// local copy of the table, and checks each result word in order.
// ----------------------------------------------------------------------------
module tb_range_address_remap_table_top;
    import rart_pkg::*;

    typedef struct {
        t_func             func;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] dbase;
    } t_cmd;

    typedef struct {
        logic [2:0]        status;
        logic [ADDR_W-1:0] daddr;
    } t_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_func;
    logic [ADDR_W-1:0] i_source_addr;
    logic [LEN_W-1:0]  i_range_length;
    logic [ADDR_W-1:0] i_dest_base;
    logic              o_valid;
    logic              i_ready;
    logic [2:0]        o_status;
    logic [ADDR_W-1:0] o_dest_addr;

    range_address_remap_table_top u_top (.*);

    t_cmd cmd_q[$];
    t_res exp_q[$];
    int   errors = 0;
    int   send_idle_pct = 12;
    int   recv_idle_pct = 75;
    bit   hold_send = 0;
    bit   stim_done = 0;
    longint cycles = 0;

    // local table copy
    bit                tbl_vld[ENTRIES];
    logic [ADDR_W-1:0] tbl_base[ENTRIES];
    logic [LEN_W-1:0]  tbl_len[ENTRIES];
    logic [ADDR_W-1:0] tbl_dbase[ENTRIES];

    function automatic t_res predict_remap(t_cmd c);
        t_res r;
        int hit, slot;
        logic [ADDR_W-1:0] off;
        bit in_range;
        r.status = ST_OK;
        r.daddr  = '0;
        hit = -1;
        off = '0;
        in_range = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_vld[i] && tbl_base[i] <= c.addr)
                if (hit < 0 || tbl_base[i] > tbl_base[hit]) hit = i;
        if (hit >= 0) begin
            off = c.addr - tbl_base[hit];
            in_range = off < {16'd0, tbl_len[hit]};
        end
        case (c.func)
            FUNC_ADD: begin
                if (in_range) begin
                    r.status = ST_ALREADY;
                end else begin
                    slot = -1;
                    if (hit >= 0 && off == '0) slot = hit;
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !tbl_vld[i]) slot = i;
                    if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_vld[slot] = 1'b1;
                        tbl_base[slot] = c.addr;
                        tbl_len[slot] = c.len;
                        tbl_dbase[slot] = c.dbase;
                        r.daddr = c.dbase;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (!in_range) r.status = ST_NOT_MAPPED;
                else if (off != '0) r.status = ST_OFFSET;
                else tbl_vld[hit] = 1'b0;
            end
            FUNC_REMAP: begin
                if (!in_range) r.status = ST_NOT_MAPPED;
                else r.daddr = tbl_dbase[hit] + off;
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (cmd_q.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                t_cmd c;
                c = cmd_q.pop_front();
                exp_q.push_back(predict_remap(c));
                i_valid        <= 1'b1;
                i_func         <= c.func;
                i_source_addr  <= c.addr;
                i_range_length <= c.len;
                i_dest_base    <= c.dbase;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (exp_q.size() == 0) begin
                    $display("%0t: unexpected word status=%0d addr=%h", $time,
                             o_status, o_dest_addr);
                    errors++;
                end else begin
                    t_res e;
                    e = exp_q.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                        errors++;
                    end
                    if (o_dest_addr !== e.daddr) begin
                        $display("%0t: dest_addr exp %h got %h", $time, e.daddr,
                                 o_dest_addr);
                        errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // base pool keeps adds, removes and remaps hitting each other
    logic [ADDR_W-1:0] pool[24];

    function automatic t_cmd mk(t_func f, logic [ADDR_W-1:0] a,
                                logic [LEN_W-1:0] l, logic [ADDR_W-1:0] d);
        t_cmd c;
        c.func = f; c.addr = a; c.len = l; c.dbase = d;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] rnd48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[ADDR_W-1:0];
    endfunction

    task automatic wait_drain();
        while (cmd_q.size() > 0 || exp_q.size() > 0 || i_valid) @(posedge i_clk);
    endtask

    initial begin
        logic [ADDR_W-1:0] amax;
        logic [ADDR_W-1:0] b;
        int k;
        amax = '1;
        i_rst_n = 0; i_valid = 0; i_ready = 0;
        i_func = FUNC_NOP; i_source_addr = '0; i_range_length = '0; i_dest_base = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed
        cmd_q.push_back(mk(FUNC_REMAP, 48'h0, '0, '0));
        cmd_q.push_back(mk(FUNC_REMOVE, 48'h1000, '0, '0));
        cmd_q.push_back(mk(FUNC_ADD, 48'h1000, 32'h100, amax - 48'h10));
        cmd_q.push_back(mk(FUNC_REMAP, 48'h10ff, '0, '0));
        cmd_q.push_back(mk(FUNC_REMAP, 48'h1100, '0, '0));
        cmd_q.push_back(mk(FUNC_ADD, 48'h1080, 32'h10, 48'h5));
        cmd_q.push_back(mk(FUNC_REMOVE, 48'h1010, '0, '0));
        cmd_q.push_back(mk(FUNC_ADD, 48'h2000, 32'h0, 48'h7));
        cmd_q.push_back(mk(FUNC_REMAP, 48'h2000, '0, '0));
        cmd_q.push_back(mk(FUNC_ADD, 48'h2000, 32'h8, 48'h9));
        cmd_q.push_back(mk(FUNC_ADD, 48'h0f00, 32'hffff, 48'h0));
        cmd_q.push_back(mk(FUNC_REMAP, 48'h1200, '0, '0));
        cmd_q.push_back(mk(FUNC_ADD, 48'h0, 32'hffffffff, amax));
        cmd_q.push_back(mk(FUNC_ADD, amax, 32'hffffffff, amax));
        cmd_q.push_back(mk(FUNC_REMAP, amax, '0, '0));
        cmd_q.push_back(mk(FUNC_NOP, amax, 32'hffffffff, amax));
        for (int i = 0; i < 6; i++)
            cmd_q.push_back(mk(FUNC_ADD, 48'h100000 * (i + 1), 32'h10, 48'h1));
        cmd_q.push_back(mk(FUNC_ADD, 48'hA00000, 32'h1, 48'h2));
        cmd_q.push_back(mk(FUNC_REMOVE, 48'h1000, '0, '0));
        cmd_q.push_back(mk(FUNC_ADD, 48'hB00000, 32'h1, 48'h3));

        // sender holds a queued word until every result is back
        while (cmd_q.size() > 0) @(posedge i_clk);
        hold_send = 1;
        cmd_q.push_back(mk(FUNC_REMAP, 48'hA00000, '0, '0));
        while (exp_q.size() > 0 || i_valid) @(posedge i_clk);
        hold_send = 0;
        wait_drain();

        for (int i = 0; i < 24; i++) pool[i] = (i % 4 == 0) ? rnd48() : 48'h10000 * i;
        for (int n = 0; n < 1800; n++) begin
            if (n == 600) begin
                wait_drain();
                send_idle_pct = 75; recv_idle_pct = 12;
            end
            if (n == 1200) begin
                wait_drain();
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            b = pool[$urandom_range(23)];
            k = $urandom_range(99);
            if (k < 35)
                cmd_q.push_back(mk(FUNC_ADD, b, ($urandom_range(9) == 0) ? 32'h0 :
                    (($urandom_range(9) == 0) ? $urandom() : $urandom_range(32'h20000)),
                    rnd48()));
            else if (k < 55)
                cmd_q.push_back(mk(FUNC_REMOVE,
                    ($urandom_range(3) == 0) ? b + $urandom_range(64) : b, '0, '0));
            else if (k < 90)
                cmd_q.push_back(mk(FUNC_REMAP, b + $urandom_range(32'h20000), '0, '0));
            else
                cmd_q.push_back(mk(t_func'($urandom_range(3)), rnd48(), $urandom(),
                                   rnd48()));
            if (cmd_q.size() > 8) while (cmd_q.size() > 4) @(posedge i_clk);
        end
        wait_drain();
        repeat (40) @(posedge i_clk);
        stim_done = 1;
    end

    initial begin
        wait (stim_done || cycles > 400000);
        if (!stim_done) begin
            $display("tb_range_address_remap_table_top: FAIL");
        end else if (errors == 0) begin
            $display("tb_range_address_remap_table_top: PASS");
        end else begin
            $display("tb_range_address_remap_table_top: FAIL");
        end
        $finish;
    end
endmodule
